// ----- sv/assert_macros.svh -----
// assertion macros for the rtl of the combinadic unranking block
// depends on nothing; the macros expect clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CUB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define CUB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define CUB_ASSERT_IMP(lbl, ante, cons)
`define CUB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- sv/cub_pkg.sv -----
// constants and types of the combinadic unranking block
// used by every module of the block but cub_ram; depends on nothing
package cub_pkg;

  localparam int KEY_BYTES  = 32;
  localparam int MAX_WEIGHT = 8;
  localparam int KEY_BITS   = KEY_BYTES * 8;
  localparam int WORD_W     = 64;
  localparam int NUM_WORDS  = (KEY_BYTES + 7) / 8;
  localparam int PAD_W      = NUM_WORDS * WORD_W;
  localparam int ORD_W      = 49;
  localparam int CFG_W      = 4;
  localparam int WIDX_W     = 2;
  localparam int ADDR_W     = $clog2(KEY_BITS);
  localparam int WT_W       = $clog2(MAX_WEIGHT + 1);
  localparam int WSEL_W     = (MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1;
  localparam logic [CFG_W-1:0] WEIGHT_RESET = CFG_W'(4);

  // one row of pascal's triangle: entry j holds C(p, j+1)
  typedef logic [MAX_WEIGHT-1:0][ORD_W-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic done;
    logic oor;
  } walk_stat_t;

endpackage

// ----- sv/combination_unrank_bitmask_core.sv -----
// Combinadic unranking core: turns an ordinal into a key mask with 'weight' bits set.
// Channels: cfg (cfg_valid/cfg_ready, cfg_weight) writes the weight register,
// reset value 4, values above 8 act as 8; write it only while the block is idle.
// in (in_valid/in_ready, in_ordinal) takes one ordinal. out (out_valid/out_ready)
// returns the mask as 64-bit words, word 0 first, with out_word_index,
// out_out_of_range (same on every word) and out_last_word on the final word.
// After reset the binomial table is built, one row per cycle, KEY_BITS rows
// (256 at 32 key bytes); in_ready stays low until it is done.
// The walk visits one bit position per cycle through a single compare and
// subtract fed by the table ram; the words then follow one per cycle while
// out_ready is high, and a stall holds the current word. The next ordinal is
// taken only after the last word of the previous mask is taken.
// depends on cub_pkg, cub_ram, cub_table, cub_walk and assert_macros.svh
`include "assert_macros.svh"
module combination_unrank_bitmask_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cub_pkg::CFG_W-1:0]   cfg_weight,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cub_pkg::ORD_W-1:0]   in_ordinal,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cub_pkg::WORD_W-1:0]  out_mask_word,
  output logic [cub_pkg::WIDX_W-1:0]  out_word_index,
  output logic                        out_out_of_range,
  output logic                        out_last_word
);
  import cub_pkg::*;

  typedef enum logic [1:0] {IDLE, BUSY, SEND} state_t;

  state_t              state_r;
  logic [CFG_W-1:0]    weight_r;
  logic                out_valid_r;
  logic [WORD_W-1:0]   out_word_r;
  logic [WIDX_W-1:0]   out_idx_r;
  logic                out_oor_r;
  logic                out_last_r;

  logic                tbl_we;
  logic [ADDR_W-1:0]   tbl_waddr;
  row_t                tbl_wdata;
  row_t                top_row;
  logic                tbl_ready;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ROW_W-1:0]    rd_data;
  walk_stat_t          stat;
  logic [KEY_BITS-1:0] mask;
  logic [PAD_W-1:0]    mask_pad;
  logic [WT_W-1:0]     w_sat;
  logic                in_fire;
  logic [WIDX_W-1:0]   idx_nxt;
  logic [WIDX_W-1:0]   idx_last;
  logic                word_step;

  cub_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (tbl_we),
    .waddr   (tbl_waddr),
    .wdata   (tbl_wdata),
    .top_row (top_row),
    .ready   (tbl_ready)
  );

  cub_ram #(
    .WIDTH (ROW_W),
    .DEPTH (KEY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  cub_walk u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_fire),
    .ordinal (in_ordinal),
    .weight  (w_sat),
    .top_row (top_row),
    .raddr   (rd_addr),
    .rdata   (rd_data),
    .stat    (stat),
    .mask    (mask)
  );

  always_comb begin
    w_sat     = (weight_r > CFG_W'(MAX_WEIGHT)) ? WT_W'(MAX_WEIGHT) : weight_r[WT_W-1:0];
    in_ready  = (state_r == IDLE) && tbl_ready;
    in_fire   = in_valid && in_ready;
    mask_pad  = PAD_W'(mask);
    idx_nxt   = out_idx_r + WIDX_W'(1);
    idx_last  = WIDX_W'(NUM_WORDS - 1);
    word_step = out_valid && out_ready && !out_last_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      weight_r    <= WEIGHT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        weight_r <= cfg_weight;
      end
      unique case (state_r)
        IDLE: begin
          if (in_fire) begin
            state_r <= BUSY;
          end
        end
        BUSY: begin
          if (stat.done) begin
            out_word_r  <= mask_pad[WORD_W-1:0];
            out_idx_r   <= '0;
            out_oor_r   <= stat.oor;
            out_last_r  <= (NUM_WORDS == 1);
            out_valid_r <= 1'b1;
            state_r     <= SEND;
          end
        end
        SEND: begin
          if (out_ready) begin
            if (out_last_r) begin
              out_valid_r <= 1'b0;
              state_r     <= IDLE;
            end else begin
              out_idx_r  <= idx_nxt;
              out_word_r <= mask_pad[idx_nxt*WORD_W +: WORD_W];
              out_last_r <= (idx_nxt == idx_last);
            end
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_mask_word    = out_word_r;
  assign out_word_index   = out_idx_r;
  assign out_out_of_range = out_oor_r;
  assign out_last_word    = out_last_r;

  // a new ordinal never enters while words of the previous mask are pending
  `CUB_ASSERT_IMP(a_no_overlap, in_valid && in_ready, !out_valid)
  `CUB_ASSERT_IMP(a_last_index, out_valid && out_last_word, out_word_index == idx_last)
  `CUB_ASSERT_NXT(a_word_order, word_step, out_valid && out_word_index == $past(idx_nxt))

endmodule

// ----- sv/cub_ram.sv -----
// generic single write, single read port ram with registered read data
// depends on nothing
module cub_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/cub_table.sv -----
// builds the binomial table row by row after reset and writes it to the ram
// depends on cub_pkg; keeps the row for p = KEY_BITS for the range check
module cub_table (
  input  logic                        clk,
  input  logic                        rst_n,
  output logic                        we,
  output logic [cub_pkg::ADDR_W-1:0]  waddr,
  output cub_pkg::row_t               wdata,
  output cub_pkg::row_t               top_row,
  output logic                        ready
);
  import cub_pkg::*;

  typedef enum logic {FILL, DONE} state_t;

  state_t            state_r;
  logic [ADDR_W-1:0] p_r;
  row_t              row_r;
  row_t              row_nxt;

  // C(p+1, j) = C(p, j) + C(p, j-1), with C(p, 0) = 1
  always_comb begin
    row_nxt[0] = row_r[0] + ORD_W'(1);
    for (int j = 1; j < MAX_WEIGHT; j++) begin
      row_nxt[j] = row_r[j] + row_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FILL;
      p_r     <= '0;
      row_r   <= '0;
    end else if (state_r == FILL) begin
      row_r <= row_nxt;
      p_r   <= p_r + ADDR_W'(1);
      if (p_r == ADDR_W'(KEY_BITS - 1)) begin
        state_r <= DONE;
      end
    end
  end

  assign we      = (state_r == FILL);
  assign waddr   = p_r;
  assign wdata   = row_r;
  assign top_row = row_r;
  assign ready   = (state_r == DONE);

endmodule

// ----- sv/cub_walk.sv -----
// greedy combinadic walk: one bit position per cycle through one compare and subtract
// depends on cub_pkg; reads one table row per cycle from the binomial ram
module cub_walk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cub_pkg::ORD_W-1:0]   ordinal,
  input  logic [cub_pkg::WT_W-1:0]    weight,
  input  cub_pkg::row_t               top_row,
  output logic [cub_pkg::ADDR_W-1:0]  raddr,
  input  cub_pkg::row_t               rdata,
  output cub_pkg::walk_stat_t         stat,
  output logic [cub_pkg::KEY_BITS-1:0] mask
);
  import cub_pkg::*;

  typedef enum logic [1:0] {IDLE, PRIME, WALK} state_t;

  state_t              state_r;
  logic [ADDR_W-1:0]   steps_r;
  logic [ORD_W-1:0]    rem_r;
  logic [WT_W-1:0]     left_r;
  logic [KEY_BITS-1:0] mask_r;
  logic                oor_r;
  logic                done_r;

  logic [ORD_W-1:0]    lim;
  logic [ORD_W-1:0]    coef;
  logic                take;

  always_comb begin
    lim  = (weight == '0) ? ORD_W'(1) : top_row[WSEL_W'(weight - WT_W'(1))];
    coef = rdata[WSEL_W'(left_r - WT_W'(1))];
    take = (left_r != '0) && (rem_r >= coef);
    // the ram read data is registered, so ask for the next position ahead
    raddr = (state_r == PRIME) ? ADDR_W'(KEY_BITS - 1) : steps_r - ADDR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        IDLE: begin
          if (start) begin
            rem_r   <= ordinal;
            left_r  <= weight;
            oor_r   <= (ordinal >= lim);
            mask_r  <= '0;
            steps_r <= ADDR_W'(KEY_BITS - 1);
            state_r <= PRIME;
          end
        end
        PRIME: begin
          state_r <= WALK;
        end
        WALK: begin
          // top position goes in first and ends at the top of the mask
          mask_r <= {mask_r[KEY_BITS-2:0], take};
          if (take) begin
            rem_r  <= rem_r - coef;
            left_r <= left_r - WT_W'(1);
          end
          if (steps_r == '0) begin
            state_r <= IDLE;
            done_r  <= 1'b1;
          end else begin
            steps_r <= steps_r - ADDR_W'(1);
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

  assign stat.done = done_r;
  assign stat.oor  = oor_r;
  assign mask      = mask_r;

endmodule

// ----- bench/cub_mask_checker.sv -----
// checker for the combinadic unranking core: follows the weight register, predicts
// the mask words of every accepted ordinal and compares the words that come out
// depends on cub_pkg
module cub_mask_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [cub_pkg::CFG_W-1:0]   cfg_weight,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [cub_pkg::ORD_W-1:0]   in_ordinal,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [cub_pkg::WORD_W-1:0]  out_mask_word,
  input  logic [cub_pkg::WIDX_W-1:0]  out_word_index,
  input  logic                        out_out_of_range,
  input  logic                        out_last_word,
  output int                          fail_count,
  output int                          words_pending,
  output int                          words_checked,
  output int                          masks_flagged,
  output logic [63:0]                 combos
);
  import cub_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] mask;
    logic [WIDX_W-1:0] idx;
    logic              oor;
    logic              last;
  } mask_word_t;

  mask_word_t       mask_words_due[$];
  mask_word_t       due;
  logic [CFG_W-1:0] weight_reg;

  function automatic int clamp_weight(input logic [CFG_W-1:0] w);
    return (int'(w) > MAX_WEIGHT) ? MAX_WEIGHT : int'(w);
  endfunction

  // C(n, k), zero when k > n; each partial product divides exactly
  function automatic logic [63:0] choose(input int n, input int k);
    logic [63:0] c;
    int i;
    c = 64'd1;
    if (k > n) return 64'd0;
    for (i = 0; i < k; i++) c = c * 64'(n - i) / 64'(i + 1);
    return c;
  endfunction

  // number of masks of the current weight, so the stimulus can aim inside the range
  assign combos = choose(KEY_BITS, clamp_weight(weight_reg));

  task automatic predict_mask(input logic [ORD_W-1:0] ordinal);
    logic [PAD_W-1:0] bits;
    logic [63:0] rest;
    logic [63:0] c;
    logic flag;
    int left;
    int p;
    int k;
    mask_word_t w;
    bits = '0;
    rest = 64'(ordinal);
    left = clamp_weight(weight_reg);
    flag = (rest >= choose(KEY_BITS, left));
    // top-down greedy walk; out of range ordinals fill the low positions once c hits zero
    for (p = KEY_BITS - 1; p >= 0 && left > 0; p--) begin
      c = choose(p, left);
      if (rest >= c) begin
        rest = rest - c;
        bits[p] = 1'b1;
        left--;
      end
    end
    if (flag) masks_flagged++;
    for (k = 0; k < NUM_WORDS; k++) begin
      w.mask = bits[k*WORD_W +: WORD_W];
      w.idx  = WIDX_W'(k);
      w.oor  = flag;
      w.last = (k == NUM_WORDS - 1);
      mask_words_due.push_back(w);
    end
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: word %0d field %s mismatch, expected %h, actual %h",
               $time, words_checked, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      weight_reg = WEIGHT_RESET;
      mask_words_due.delete();
      fail_count = 0;
      words_checked = 0;
      masks_flagged = 0;
    end else begin
      if (in_valid && in_ready) predict_mask(in_ordinal);
      if (out_valid && out_ready) begin
        if (mask_words_due.size() == 0) begin
          fail_count++;
          $display("%0t: word with nothing expected, expected none, actual %h index %0d",
                   $time, out_mask_word, out_word_index);
        end else begin
          due = mask_words_due.pop_front();
          check_field("mask_word", 64'(due.mask), 64'(out_mask_word));
          check_field("word_index", 64'(due.idx), 64'(out_word_index));
          check_field("out_of_range", 64'(due.oor), 64'(out_out_of_range));
          check_field("last_word", 64'(due.last), 64'(out_last_word));
          words_checked++;
        end
      end
      if (cfg_valid && cfg_ready) weight_reg = cfg_weight;
    end
    words_pending = mask_words_due.size();
  end

endmodule

// ----- bench/tb_combination_unrank_bitmask_core.sv -----
// testbench top for the combinadic unranking core: drives ordinals and weight writes,
// stalls the mask words at random and gives the verdict
// depends on cub_pkg, combination_unrank_bitmask_core and cub_mask_checker
module tb_combination_unrank_bitmask_core;
  import cub_pkg::*;

  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 40;
  localparam int LONG_HOLD   = 1000;
  localparam int TAIL_CYCLES = 300;
  localparam logic [PHASES*CFG_W-1:0] PHASE_WEIGHTS = {
    4'd4, 4'd12, 4'd7, 4'd1, 4'd6, 4'd9, 4'd5, 4'd2, 4'd15, 4'd3, 4'd0, 4'd8
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_weight;
  logic              in_valid;
  logic              in_ready;
  logic [ORD_W-1:0]  in_ordinal;
  logic              out_valid;
  logic              out_ready;
  logic [WORD_W-1:0] out_mask_word;
  logic [WIDX_W-1:0] out_word_index;
  logic              out_out_of_range;
  logic              out_last_word;

  int          fail_count;
  int          words_pending;
  int          words_checked;
  int          masks_flagged;
  logic [63:0] combos;
  logic [63:0] ordinal_span;
  bit          calm = 1'b1;
  bit          long_hold_req = 1'b0;
  int          ordinals_sent = 0;
  int          weight_writes = 0;

  combination_unrank_bitmask_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_weight       (cfg_weight),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ordinal       (in_ordinal),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mask_word    (out_mask_word),
    .out_word_index   (out_word_index),
    .out_out_of_range (out_out_of_range),
    .out_last_word    (out_last_word)
  );

  cub_mask_checker u_mask_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_weight       (cfg_weight),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ordinal       (in_ordinal),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mask_word    (out_mask_word),
    .out_word_index   (out_word_index),
    .out_out_of_range (out_out_of_range),
    .out_last_word    (out_last_word),
    .fail_count       (fail_count),
    .words_pending    (words_pending),
    .words_checked    (words_checked),
    .masks_flagged    (masks_flagged),
    .combos           (combos)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // no gap while calm, else mostly none, some short ones, a few long enough to leave the core idle
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 5);
    return $urandom_range(20, 300);
  endfunction

  function automatic logic [ORD_W-1:0] pick_ordinal();
    logic [63:0] raw;
    int r;
    raw = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 75) return ORD_W'(raw % ordinal_span);
    if (r < 85) return ORD_W'(ordinal_span + 64'($urandom_range(0, 3)) - 64'd2);
    return ORD_W'(raw);
  endfunction

  // called at a rising edge, returns at the edge that takes the ordinal
  task automatic send_ordinal(input logic [ORD_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_ordinal <= v;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    ordinals_sent++;
  endtask

  task automatic drain_masks();
    in_valid <= 1'b0;
    @(negedge clk);
    while (words_pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_weight(input logic [CFG_W-1:0] w);
    cfg_valid  <= 1'b1;
    cfg_weight <= w;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    weight_writes++;
    // the checker picks up the new weight at this edge; read its range at the falling edge after it
    @(negedge clk);
    ordinal_span = combos;
    @(posedge clk);
  endtask

  initial begin
    int i;
    int n;
    rst_n      <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_weight <= '0;
    in_valid   <= 1'b0;
    in_ordinal <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    ordinal_span = combos;

    // reset weight: range edges and alternating bit patterns
    send_ordinal('0);
    send_ordinal(ORD_W'(1));
    send_ordinal(ORD_W'(ordinal_span - 64'd1));
    send_ordinal(ORD_W'(ordinal_span));
    send_ordinal('1);
    send_ordinal(49'h0_AAAA_AAAA_AAAA);
    send_ordinal(49'h1_5555_5555_5555);
    send_ordinal(ORD_W'(1) << (ORD_W - 1));
    drain_masks();

    // zero weight: empty mask, anything but zero is flagged
    write_weight(4'd0);
    send_ordinal('0);
    send_ordinal(ORD_W'(1));
    send_ordinal('1);
    drain_masks();

    // weight above the maximum saturates
    write_weight(4'd15);
    send_ordinal('0);
    send_ordinal(ORD_W'(ordinal_span - 64'd1));
    send_ordinal(ORD_W'(ordinal_span));
    send_ordinal('1);
    drain_masks();

    write_weight(4'd1);
    send_ordinal('0);
    send_ordinal(ORD_W'(ordinal_span - 64'd1));
    send_ordinal(ORD_W'(ordinal_span));
    send_ordinal('1);
    drain_masks();

    for (i = 0; i < PHASES; i++) begin
      write_weight(PHASE_WEIGHTS[i*CFG_W +: CFG_W]);
      calm = (i % 4 == 3);
      // hold the word output off for a long stretch so the input backs up
      if (i == 2) long_hold_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) send_ordinal(pick_ordinal());
      drain_masks();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d ordinals over %0d weight writes, zero and saturated weights too",
             ordinals_sent, weight_writes);
    $display("%0d mask words compared, %0d masks flagged out of range",
             words_checked, masks_flagged);
    if (fail_count == 0 && words_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // word sink: random stalls, plus one long hold on request
  initial begin
    int n;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    #50_000_000;
    $display("timeout with %0d mask words outstanding", words_pending);
    $display("TB_ERROR");
    $finish;
  end

endmodule
